// ===== rtl/core/b64e_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  // Lines shorter than this act as this length.
  localparam logic [7:0] MinLine = 8'd5;
  localparam logic [7:0] LineLengthReset = 8'd76;
  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [7:0] NewlineChar = 8'h0A;

  // Open characters one input byte can produce, newlines and terminator excluded.
  localparam int unsigned MaxChars = 4;
  localparam int unsigned CharIdxW = $clog2(MaxChars);
  localparam int unsigned CharCntW = $clog2(MaxChars + 1);

  // Input transaction: one message byte and the end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } b64e_in_t;

  // Output transaction: one ASCII character and the terminator flag.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } b64e_out_t;

  // Map a 6-bit value to its character in the standard base64 alphabet.
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base64_line_wrapped_encoder_top.sv =====
// The characters of a byte pass through the character buffer, then the output register.
// Throughput: one output character per cycle while the output is not stalled; a byte causes
// one to six characters, emitted one at a time by the single character emitter feeding the output register.
// A new byte is taken in the cycle the previous byte's last character is emitted.
// Reset (rst_ni low, asynchronous) clears the group phase, carry bits, line count, valid
// flags, and sets the line length to 76.
`timescale 1ns / 1ps
`default_nettype none

module base64_line_wrapped_encoder_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write channel: line length.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i,
  // Input byte channel.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire b64e_pkg::b64e_in_t in_data_i,
  // Output character channel.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output b64e_pkg::b64e_out_t     out_data_o
);

  // Configuration and encoder state.
  logic [7:0] line_len_q;
  logic [1:0] phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [7:0] count_q, count_d;

  // Character buffer for the byte being emitted.
  logic [7:0]                      chars_q [b64e_pkg::MaxChars];
  logic [7:0]                      chars_d [b64e_pkg::MaxChars];
  logic [b64e_pkg::CharCntW-1:0]   ncnt_q, ncnt_d;
  logic [b64e_pkg::CharCntW-1:0]   idx_q, idx_d;
  logic                            term_q, term_d;
  logic                            nl_q, nl_d;
  logic                            busy_q, busy_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  b64e_pkg::b64e_out_t  out_data_q, out_data_d;

  logic       out_ready;
  logic       step;
  logic       finish;
  logic       in_acc;
  logic [7:0] len_eff;
  logic [8:0] cnt_inc;
  logic       nl_need;
  logic       char_sel;
  logic [7:0] cur_char;

  assign cfg_ready_o = 1'b1;

  // Emission control.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign step      = busy_q && out_ready;
  assign len_eff   = (line_len_q < b64e_pkg::MinLine) ? b64e_pkg::MinLine : line_len_q;
  assign cnt_inc   = {1'b0, count_q} + 9'd1;
  assign nl_need   = cnt_inc >= {1'b0, len_eff};
  assign char_sel  = !nl_q && (idx_q < ncnt_q);
  assign cur_char  = chars_q[idx_q[b64e_pkg::CharIdxW-1:0]];

  // The current emission is the last one of this byte.
  always_comb begin
    if (nl_q) begin
      finish = (idx_q == ncnt_q) && !term_q;
    end else if (char_sel) begin
      finish = !nl_need && (idx_q + b64e_pkg::CharCntW'(1) == ncnt_q) && !term_q;
    end else begin
      finish = 1'b1;
    end
  end

  assign in_stall_o = busy_q && !(step && finish);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Build the character list of an incoming byte from the group phase and carry bits.
  always_comb begin
    phase_d = phase_q;
    carry_d = carry_q;
    for (int i = 0; i < b64e_pkg::MaxChars; i++) begin
      chars_d[i] = chars_q[i];
    end
    ncnt_d = ncnt_q;
    term_d = term_q;
    if (in_acc) begin
      term_d = in_data_i.final_byte;
      unique case (phase_q)
        2'd0: begin
          chars_d[0] = b64e_pkg::sym(in_data_i.data_byte[7:2]);
          chars_d[1] = b64e_pkg::sym({in_data_i.data_byte[1:0], 4'b0000});
          chars_d[2] = b64e_pkg::PadChar;
          chars_d[3] = b64e_pkg::PadChar;
          ncnt_d     = in_data_i.final_byte ? b64e_pkg::CharCntW'(4) : b64e_pkg::CharCntW'(1);
          carry_d    = {2'b00, in_data_i.data_byte[1:0]};
          phase_d    = 2'd1;
        end
        2'd1: begin
          chars_d[0] = b64e_pkg::sym({carry_q[1:0], in_data_i.data_byte[7:4]});
          chars_d[1] = b64e_pkg::sym({in_data_i.data_byte[3:0], 2'b00});
          chars_d[2] = b64e_pkg::PadChar;
          ncnt_d     = in_data_i.final_byte ? b64e_pkg::CharCntW'(3) : b64e_pkg::CharCntW'(1);
          carry_d    = in_data_i.data_byte[3:0];
          phase_d    = 2'd2;
        end
        default: begin
          chars_d[0] = b64e_pkg::sym({carry_q, in_data_i.data_byte[7:6]});
          chars_d[1] = b64e_pkg::sym(in_data_i.data_byte[5:0]);
          ncnt_d     = b64e_pkg::CharCntW'(2);
          carry_d    = 4'd0;
          phase_d    = 2'd0;
        end
      endcase
      if (in_data_i.final_byte) begin
        carry_d = 4'd0;
        phase_d = 2'd0;
      end
    end
  end

  // Step through the buffer: characters, inserted newlines, then the terminator.
  always_comb begin
    idx_d       = idx_q;
    nl_d        = nl_q;
    count_d     = count_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (step) begin
      out_valid_d = 1'b1;
      if (nl_q) begin
        out_data_d = '{out_char: b64e_pkg::NewlineChar, last_char: 1'b0};
        nl_d       = 1'b0;
      end else if (char_sel) begin
        out_data_d = '{out_char: cur_char, last_char: 1'b0};
        idx_d      = idx_q + b64e_pkg::CharCntW'(1);
        nl_d       = nl_need;
        count_d    = nl_need ? 8'd1 : cnt_inc[7:0];
      end else begin
        out_data_d = '{out_char: b64e_pkg::PadChar, last_char: 1'b1};
        count_d    = 8'd0;
      end
      if (finish) begin
        busy_d = 1'b0;
      end
    end
    if (in_acc) begin
      idx_d  = '0;
      nl_d   = 1'b0;
      busy_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q  <= b64e_pkg::LineLengthReset;
      phase_q     <= 2'd0;
      carry_q     <= 4'd0;
      count_q     <= 8'd0;
      idx_q       <= '0;
      ncnt_q      <= '0;
      term_q      <= 1'b0;
      nl_q        <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        line_len_q <= cfg_data_i;
      end
      phase_q     <= phase_d;
      carry_q     <= carry_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      ncnt_q      <= ncnt_d;
      term_q      <= term_d;
      nl_q        <= nl_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < b64e_pkg::MaxChars; i++) begin
      chars_q[i] <= chars_d[i];
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A pending newline only exists while a byte is being emitted.
  a_nl_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_q |-> busy_q) else $error("newline pending while idle");

  // The read position never passes the number of buffered characters.
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= ncnt_q && ncnt_q != '0)) else $error("buffer index out of range");

  // An accepted byte always leaves work in the buffer.
  a_acc_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> busy_q) else $error("accepted byte lost");

  // The terminator always resets the line count.
  a_term_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !nl_q && !char_sel) |=> (count_q == 8'd0)) else $error("count not cleared");

endmodule

`default_nettype wire

// ===== tb/base64_line_wrapped_encoder_top_tb.sv =====
`timescale 1ns / 1ps

module base64_line_wrapped_encoder_top_tb;

  // Standard base64 alphabet, symbol 0 in the top byte.
  localparam logic [64*8-1:0] B64Chars =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int HoldOffAt = 90;
  localparam int HoldOffCycles = 400;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [7:0]           cfg_data_i = b64e_pkg::LineLengthReset;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  b64e_pkg::b64e_in_t   in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  b64e_pkg::b64e_out_t  out_data_o;

  // Encoder state mirrored by the testbench.
  logic [7:0]  line_len = b64e_pkg::LineLengthReset;
  logic [1:0]  grp_phase = 2'd0;
  logic [3:0]  carry = 4'd0;
  logic [7:0]  col_count = 8'd0;

  b64e_pkg::b64e_in_t   pending_bytes[$];
  b64e_pkg::b64e_out_t  expected_chars[$];

  int          idle_pct = 30;
  logic        hold_rx = 1'b0;
  int          in_gap = 0;
  int          stall_left = 0;
  int          items_sent = 0;
  int          chars_seen = 0;
  int          messages_done = 0;
  int          cfg_writes = 0;
  int          mismatches = 0;

  base64_line_wrapped_encoder_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short idle runs, now and then a long one.
  function automatic int pick_idle_run(input int pct);
    if ($urandom_range(99) >= pct) begin
      return 0;
    end
    if ($urandom_range(9) == 0) begin
      return $urandom_range(30, 8);
    end
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    int idx;
    idx = 63 - int'(v);
    return B64Chars[idx*8 +: 8];
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic last);
    b64e_pkg::b64e_out_t c;
    c.out_char = ch;
    c.last_char = last;
    expected_chars.push_back(c);
  endfunction

  // One character followed by a newline when the line fills up.
  function automatic void put_wrapped(input logic [7:0] ch);
    int span;
    int next_count;
    span = (line_len < b64e_pkg::MinLine) ? int'(b64e_pkg::MinLine) : int'(line_len);
    next_count = int'(col_count) + 1;
    push_char(ch, 1'b0);
    if (next_count >= span) begin
      push_char(b64e_pkg::NewlineChar, 1'b0);
      next_count = 1;
    end
    col_count = next_count[7:0];
  endfunction

  // Work out the characters that one message byte produces.
  function automatic void encode_byte(input b64e_pkg::b64e_in_t item);
    logic [7:0] b;
    b = item.data_byte;
    case (grp_phase)
      2'd0: begin
        put_wrapped(b64_char(b[7:2]));
        carry = {2'b00, b[1:0]};
        grp_phase = 2'd1;
        if (item.final_byte) begin
          put_wrapped(b64_char({carry[1:0], 4'b0000}));
          put_wrapped(b64e_pkg::PadChar);
          put_wrapped(b64e_pkg::PadChar);
        end
      end
      2'd1: begin
        put_wrapped(b64_char({carry[1:0], b[7:4]}));
        carry = b[3:0];
        grp_phase = 2'd2;
        if (item.final_byte) begin
          put_wrapped(b64_char({carry, 2'b00}));
          put_wrapped(b64e_pkg::PadChar);
        end
      end
      default: begin
        put_wrapped(b64_char({carry, b[7:6]}));
        put_wrapped(b64_char(b[5:0]));
        carry = 4'd0;
        grp_phase = 2'd0;
      end
    endcase
    if (item.final_byte) begin
      push_char(b64e_pkg::PadChar, 1'b1);
      grp_phase = 2'd0;
      carry = 4'd0;
      col_count = 8'd0;
    end
  endfunction

  // Byte driver: predicts each accepted transaction and offers the next one.
  always @(posedge clk_i) begin : byte_driver
    logic offering;
    if (rst_ni) begin
      offering = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        encode_byte(in_data_i);
        items_sent++;
        offering = 1'b0;
        in_gap = pick_idle_run(idle_pct);
      end
      if (!offering) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_bytes.size() > 0) begin
          in_data_i <= pending_bytes.pop_front();
          offering = 1'b1;
        end
      end
      in_valid_i <= offering;
    end
  end

  // Character monitor: checks each output transaction and drives the stall.
  always @(posedge clk_i) begin : char_monitor
    b64e_pkg::b64e_out_t want;
    logic next_stall;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        chars_seen++;
        if (out_data_o.last_char) begin
          messages_done++;
        end
        if (expected_chars.size() == 0) begin
          $error("out_char: expected nothing, actual %h", out_data_o.out_char);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data_o.out_char !== want.out_char) begin
            $error("out_char: expected %h, actual %h", want.out_char, out_data_o.out_char);
            mismatches++;
          end
          if (out_data_o.last_char !== want.last_char) begin
            $error("last_char: expected %b, actual %b", want.last_char,
                   out_data_o.last_char);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
        stall_left = pick_idle_run(idle_pct);
      end
      out_stall_i <= next_stall | hold_rx;
    end
  end

  // Long receiver hold-off while bytes keep coming, so the input backs up.
  initial begin : rx_hold_off
    wait (items_sent >= HoldOffAt);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("base64_line_wrapped_encoder_top test failed");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic fin);
    b64e_pkg::b64e_in_t item;
    item.data_byte = b;
    item.final_byte = fin;
    pending_bytes.push_back(item);
  endtask

  task automatic add_random_message(input int n, input logic close);
    for (int i = 0; i < n; i++) begin
      push_byte(8'($urandom_range(255)), close && (i == n - 1));
    end
  endtask

  // Wait until every byte is taken and every character has come out.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid_i || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_line_length(input logic [7:0] v);
    @(posedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    line_len = v;
    cfg_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : sequencer
    int lengths[8];
    int pct_choice[3];
    int phase_items;
    int n;
    lengths = '{255, 5, 4, 1, 76, 0, 2, 64};
    pct_choice = '{0, 30, 60};
    lengths[5] = $urandom_range(255, 1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single-byte, two-byte, full-group and four-byte messages at the reset length.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFB, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBE, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_drained();

    // A zero length acts as the minimum line, so newlines come thick.
    set_line_length(8'd0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_drained();
    set_line_length(8'd1);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);
    wait_drained();

    // Lower the line length in the middle of a message, below the current count.
    set_line_length(8'd20);
    add_random_message(6, 1'b0);
    wait_drained();
    set_line_length(8'd6);
    push_byte(8'hA5, 1'b1);
    wait_drained();

    // Random messages under several line lengths; some phases stop mid-message.
    foreach (lengths[p]) begin
      set_line_length(8'(lengths[p]));
      idle_pct = pct_choice[$urandom_range(2)];
      phase_items = 0;
      while (phase_items < 22) begin
        case ($urandom_range(19))
          0: n = $urandom_range(120, 41);
          1, 2, 3, 4, 5: n = $urandom_range(40, 10);
          default: n = $urandom_range(9, 1);
        endcase
        phase_items += n;
        add_random_message(n, (phase_items < 22) || (p == 7) || ($urandom_range(9) >= 3));
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("Covered %0d messages: %0d input bytes encoded into %0d characters.",
             messages_done, items_sent, chars_seen);
    $display("Line length was set %0d times, from 0 up to 255, with long output stalls.",
             cfg_writes);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("base64_line_wrapped_encoder_top test passed");
    end else begin
      $display("base64_line_wrapped_encoder_top test failed");
    end
    $finish;
  end

endmodule
